>>> rtl/atlas_tile_cache_lru_unit_defines.svh
// Assertion macros for the atlas tile cache.
`ifndef ATLAS_TILE_CACHE_LRU_UNIT_DEFINES_SVH
`define ATLAS_TILE_CACHE_LRU_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ATC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ATC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ATC_ASSERT(lbl, prop, msg)
`define ATC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/atc_pkg.sv
// Shared types and constants of the atlas tile cache.
`timescale 1ns / 1ps
package atc_pkg;

  localparam int MaxTiles = 256;
  localparam int Slots    = 1024;
  localparam int TileW    = 8;
  localparam int SlotW    = 10;
  localparam int CntW     = 9;

  typedef enum logic [1:0] {
    ACT_ACQUIRE     = 2'd0,
    ACT_BEGIN_FRAME = 2'd1,
    ACT_INIT        = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_READY  = 2'd0,
    ST_WAIT   = 2'd1,
    ST_UNSUPP = 2'd2,
    ST_DONE   = 2'd3
  } status_e;

  localparam logic [1:0] REG_TILES_PER_ROW = 2'd0;
  localparam logic [1:0] REG_TILE_SIZE     = 2'd1;
  localparam logic [1:0] REG_FILL_BUDGET   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  texture_slot;
    logic [31:0] identity_code;
    logic        is_supported;
    logic [31:0] frame_number;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tile_index;
    logic        needs_fill;
    logic [12:0] fill_x;
    logic [12:0] fill_y;
    logic        evicted;
    logic [8:0]  tiles_in_use;
  } result_t;

  typedef struct packed {
    logic              present;
    logic [32:0]       identity;
    logic              tile_vld;
    logic [TileW-1:0]  tile;
    logic [31:0]       last_seen;
    logic [31:0]       checked;
  } slot_rec_t;

  typedef struct packed {
    logic             vld;
    logic [SlotW-1:0] slot;
  } owner_t;

  typedef struct packed {
    logic             start;
    logic [TileW-1:0] dividend;
    logic [4:0]       divisor;
  } div_req_t;

endpackage

>>> rtl/atc_div.sv
// Restoring divider of a tile number by the row length, one quotient bit per cycle.
`timescale 1ns / 1ps
module atc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  atc_pkg::div_req_t           req_i,
  output logic [atc_pkg::TileW-1:0]   quotient_o,
  output logic [4:0]                  remainder_o,
  output logic                        done_o
);

  logic [atc_pkg::TileW-1:0] quo_q, quo_d;
  logic [4:0]                rem_q, rem_d;
  logic [4:0]                div_q, div_d;
  logic [3:0]                cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [5:0]                trial;
  logic                      take;

  assign trial = {rem_q, quo_q[atc_pkg::TileW-1]};
  assign take  = trial >= {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      div_d = req_i.divisor;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // Shift in one dividend bit and subtract when the divisor fits.
      rem_d = take ? 5'(trial - {1'b0, div_q}) : trial[4:0];
      quo_d = {quo_q[atc_pkg::TileW-2:0], take};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(atc_pkg::TileW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

>>> rtl/atlas_tile_cache_lru_unit.sv
// Top level of the atlas tile cache: slot and tile tables, free stack and sequencer.
`timescale 1ns / 1ps
`include "atlas_tile_cache_lru_unit_defines.svh"
// The block keeps the bookkeeping of a texture atlas made of square tiles.
// An item is taken when start is high and busy is low; it carries an action
// (acquire, begin frame or init) with the slot, identity and frame of the
// texture. Every item yields exactly one result, shown on result_o for one
// cycle while result_valid_o is high. The receiver cannot stall the block.
// Configuration goes through the APB port: tiles per row at 0x0, tile size
// at 0x4 and fill budget at 0x8. Tiles per row takes effect at the next init.
// Path per item: a begin frame or an unused action answers from the idle
// state, an unsupported texture or a spent budget after the slot memory read.
// An acquire that hits answers after the slot memory read and the eight-step
// divider that forms the fill origin; one that pops the free stack passes the
// pop and assign states before the divider. An acquire that must evict scans
// all 256 tile owners through a three-stage read pipeline over both memories
// and answers after the divider, or from the scan when no victim is found.
// An init, and reset too, runs a clearing pass over all 1024 entries of the
// slot memory, rebuilding the owner table and the free stack on the way; an
// init answers when the pass ends. Busy stays high during the pass and configuration
// writes are still taken. The pass after reset produces no result.
module atlas_tile_cache_lru_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  atc_pkg::item_t   item_i,
  output atc_pkg::result_t result_o,
  output logic             result_valid_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_EVW    = 4'd4;
  localparam logic [3:0] S_ASSIGN = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;

  // Configuration registers.
  logic [4:0] cfg_row_q;
  logic [9:0] cfg_size_q;
  logic [8:0] cfg_budget_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_row_q    <= 5'd16;
      cfg_size_q   <= 10'd64;
      cfg_budget_q <= 9'd16;
    end else if (cfg_we) begin
      case (paddr[3:2])
        atc_pkg::REG_TILES_PER_ROW: cfg_row_q    <= pwdata[4:0];
        atc_pkg::REG_TILE_SIZE:     cfg_size_q   <= pwdata[9:0];
        atc_pkg::REG_FILL_BUDGET:   cfg_budget_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      atc_pkg::REG_TILES_PER_ROW: prdata = {27'd0, cfg_row_q};
      atc_pkg::REG_TILE_SIZE:     prdata = {22'd0, cfg_size_q};
      atc_pkg::REG_FILL_BUDGET:   prdata = {23'd0, cfg_budget_q};
      default:                    prdata = '0;
    endcase
  end

  // Memories: slot records, tile owners and the free stack.
  atc_pkg::slot_rec_t slot_mem [atc_pkg::Slots];
  atc_pkg::owner_t    owner_mem [atc_pkg::MaxTiles];
  logic [atc_pkg::TileW-1:0] stack_mem [atc_pkg::MaxTiles];

  logic                             slot_we, slot_re;
  logic [atc_pkg::SlotW-1:0]        slot_waddr, slot_raddr;
  atc_pkg::slot_rec_t               slot_wdata, slot_rdata_q;
  logic                             owner_we, owner_re;
  logic [atc_pkg::TileW-1:0]        owner_waddr, owner_raddr;
  atc_pkg::owner_t                  owner_wdata, owner_rdata_q;
  logic                             stack_we, stack_re;
  logic [atc_pkg::TileW-1:0]        stack_waddr, stack_raddr;
  logic [atc_pkg::TileW-1:0]        stack_wdata, stack_rdata_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (owner_we) owner_mem[owner_waddr] <= owner_wdata;
    if (owner_re) owner_rdata_q <= owner_mem[owner_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata_q <= stack_mem[stack_raddr];
  end

  // Control and datapath registers.
  logic [3:0]                 state_q, state_d;
  atc_pkg::item_t             item_q, item_d;
  atc_pkg::slot_rec_t         rec_q, rec_d;
  logic [atc_pkg::TileW-1:0]  tile_q, tile_d;
  logic                       need_q, need_d;
  logic                       ev_q, ev_d;
  logic                       best_vld_q, best_vld_d;
  logic [atc_pkg::TileW-1:0]  best_tile_q, best_tile_d;
  logic [atc_pkg::SlotW-1:0]  best_slot_q, best_slot_d;
  logic [31:0]                best_frame_q, best_frame_d;
  logic [atc_pkg::CntW-1:0]   scan_idx_q, scan_idx_d;
  logic                       p1_vld_q, p1_vld_d;
  logic [atc_pkg::TileW-1:0]  p1_tile_q, p1_tile_d;
  logic                       p2_vld_q, p2_vld_d;
  logic [atc_pkg::TileW-1:0]  p2_tile_q, p2_tile_d;
  logic [atc_pkg::SlotW-1:0]  p2_slot_q, p2_slot_d;
  atc_pkg::result_t           res_q, res_d;
  logic                       res_vld_q, res_vld_d;
  logic [atc_pkg::SlotW-1:0]  clr_idx_q, clr_idx_d;
  logic                       clr_res_q, clr_res_d;
  logic [atc_pkg::CntW-1:0]   free_cnt_q, free_cnt_d;
  logic [atc_pkg::CntW-1:0]   fills_q, fills_d;
  logic [4:0]                 row_q, row_d;
  logic [atc_pkg::CntW-1:0]   cap_q, cap_d;

  // Divider for the fill origin.
  atc_pkg::div_req_t         div_req;
  logic [atc_pkg::TileW-1:0] div_quo;
  logic [4:0]                div_rem;
  logic                      div_done;

  atc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // Capacity of a tiles-per-row value: its square, capped at the table size.
  logic [9:0]               row_sq;
  logic [atc_pkg::CntW-1:0] cap_new;
  assign row_sq  = {5'd0, cfg_row_q} * {5'd0, cfg_row_q};
  assign cap_new = (row_sq > 10'(atc_pkg::MaxTiles)) ?
                   atc_pkg::CntW'(atc_pkg::MaxTiles) : row_sq[atc_pkg::CntW-1:0];

  logic [32:0]              in_id;
  atc_pkg::slot_rec_t       nrec;
  logic [atc_pkg::TileW-1:0] alloc_tile;
  logic [17:0]              prod_x, prod_y;

  assign in_id      = {item_q.is_supported, item_q.identity_code};
  assign alloc_tile = ev_q ? best_tile_q : stack_rdata_q;
  assign prod_x     = {13'd0, div_rem} * {8'd0, cfg_size_q};
  assign prod_y     = {10'd0, div_quo} * {8'd0, cfg_size_q};

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    rec_d        = rec_q;
    tile_d       = tile_q;
    need_d       = need_q;
    ev_d         = ev_q;
    best_vld_d   = best_vld_q;
    best_tile_d  = best_tile_q;
    best_slot_d  = best_slot_q;
    best_frame_d = best_frame_q;
    scan_idx_d   = scan_idx_q;
    p1_vld_d     = 1'b0;
    p1_tile_d    = p1_tile_q;
    p2_vld_d     = 1'b0;
    p2_tile_d    = p2_tile_q;
    p2_slot_d    = p2_slot_q;
    res_d        = res_q;
    res_vld_d    = 1'b0;
    clr_idx_d    = clr_idx_q;
    clr_res_d    = clr_res_q;
    free_cnt_d   = free_cnt_q;
    fills_d      = fills_q;
    row_d        = row_q;
    cap_d        = cap_q;
    nrec         = slot_rdata_q;

    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_waddr  = item_q.texture_slot;
    slot_raddr  = item_i.texture_slot;
    slot_wdata  = rec_q;
    owner_we    = 1'b0;
    owner_re    = 1'b0;
    owner_waddr = alloc_tile;
    owner_raddr = scan_idx_q[atc_pkg::TileW-1:0];
    owner_wdata = '{vld: 1'b1, slot: item_q.texture_slot};
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    stack_waddr = free_cnt_q[atc_pkg::TileW-1:0];
    stack_wdata = slot_rdata_q.tile;
    stack_raddr = 8'(free_cnt_q - 9'd1);

    div_req          = '0;
    div_req.dividend = tile_q;
    div_req.divisor  = row_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          case (item_i.action)
            atc_pkg::ACT_ACQUIRE: begin
              slot_re = 1'b1;
              state_d = S_RD;
            end
            atc_pkg::ACT_BEGIN_FRAME: begin
              fills_d   = '0;
              res_d     = '0;
              res_d.status       = atc_pkg::ST_DONE;
              res_d.tiles_in_use = cap_q - free_cnt_q;
              res_vld_d = 1'b1;
            end
            atc_pkg::ACT_INIT: begin
              row_d      = cfg_row_q;
              cap_d      = cap_new;
              free_cnt_d = cap_new;
              clr_idx_d  = '0;
              clr_res_d  = 1'b1;
              state_d    = S_CLEAR;
            end
            default: begin
              res_d     = '0;
              res_d.status       = atc_pkg::ST_DONE;
              res_d.tiles_in_use = cap_q - free_cnt_q;
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        // Recheck the identity once per frame and free a stale tile.
        if (!slot_rdata_q.present) begin
          nrec.present  = 1'b1;
          nrec.identity = in_id;
          nrec.tile_vld = 1'b0;
          nrec.checked  = item_q.frame_number;
        end else if (slot_rdata_q.checked != item_q.frame_number) begin
          nrec.checked = item_q.frame_number;
          if (slot_rdata_q.identity != in_id) begin
            if (slot_rdata_q.tile_vld) begin
              owner_we    = 1'b1;
              owner_waddr = slot_rdata_q.tile;
              owner_wdata = '0;
              if (free_cnt_q < cap_q) begin
                stack_we   = 1'b1;
                free_cnt_d = free_cnt_q + 9'd1;
              end
            end
            nrec.identity = in_id;
            nrec.tile_vld = 1'b0;
          end
        end
        nrec.last_seen = item_q.frame_number;
        slot_we    = 1'b1;
        slot_wdata = nrec;
        rec_d      = nrec;
        res_d      = '0;
        ev_d       = 1'b0;
        need_d     = 1'b0;
        if (!nrec.identity[32]) begin
          res_d.status       = atc_pkg::ST_UNSUPP;
          res_d.tiles_in_use = cap_q - free_cnt_d;
          res_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end else if (nrec.tile_vld) begin
          tile_d           = nrec.tile;
          div_req.start    = 1'b1;
          div_req.dividend = nrec.tile;
          state_d          = S_DIV;
        end else if (fills_q < cfg_budget_q && free_cnt_d != '0) begin
          state_d = S_POP;
        end else if (fills_q < cfg_budget_q) begin
          scan_idx_d   = '0;
          best_vld_d   = 1'b0;
          best_frame_d = item_q.frame_number;
          state_d      = S_SCAN;
        end else begin
          res_d.status       = atc_pkg::ST_WAIT;
          res_d.tiles_in_use = cap_q - free_cnt_d;
          res_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_POP: begin
        stack_re   = 1'b1;
        free_cnt_d = free_cnt_q - 9'd1;
        state_d    = S_ASSIGN;
      end

      S_SCAN: begin
        // Stage one reads an owner, stage two reads its slot, stage three compares.
        if (scan_idx_q != atc_pkg::CntW'(atc_pkg::MaxTiles)) begin
          owner_re   = 1'b1;
          p1_vld_d   = 1'b1;
          p1_tile_d  = scan_idx_q[atc_pkg::TileW-1:0];
          scan_idx_d = scan_idx_q + 9'd1;
        end
        if (p1_vld_q) begin
          slot_re    = 1'b1;
          slot_raddr = owner_rdata_q.slot;
          p2_vld_d   = owner_rdata_q.vld;
          p2_tile_d  = p1_tile_q;
          p2_slot_d  = owner_rdata_q.slot;
        end
        if (p2_vld_q && slot_rdata_q.present && slot_rdata_q.last_seen < best_frame_q) begin
          best_vld_d   = 1'b1;
          best_tile_d  = p2_tile_q;
          best_slot_d  = p2_slot_q;
          best_frame_d = slot_rdata_q.last_seen;
        end
        if (scan_idx_q == atc_pkg::CntW'(atc_pkg::MaxTiles) && !p1_vld_q && !p2_vld_q) begin
          if (best_vld_q) begin
            state_d = S_EVW;
          end else begin
            res_d.status       = atc_pkg::ST_WAIT;
            res_d.tiles_in_use = cap_q - free_cnt_q;
            res_vld_d          = 1'b1;
            state_d            = S_IDLE;
          end
        end
      end

      S_EVW: begin
        // The victim slot loses its tile and becomes not present.
        slot_we    = 1'b1;
        slot_waddr = best_slot_q;
        slot_wdata = '0;
        ev_d       = 1'b1;
        state_d    = S_ASSIGN;
      end

      S_ASSIGN: begin
        owner_we        = 1'b1;
        slot_we         = 1'b1;
        slot_wdata      = rec_q;
        slot_wdata.tile_vld = 1'b1;
        slot_wdata.tile = alloc_tile;
        rec_d           = slot_wdata;
        if (fills_q != 9'h1FF) fills_d = fills_q + 9'd1;
        tile_d           = alloc_tile;
        need_d           = 1'b1;
        div_req.start    = 1'b1;
        div_req.dividend = alloc_tile;
        state_d          = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          res_d.status       = atc_pkg::ST_READY;
          res_d.tile_index   = tile_q;
          res_d.needs_fill   = need_q;
          res_d.evicted      = ev_q;
          res_d.fill_x       = (row_q == '0) ? '0 : prod_x[12:0];
          res_d.fill_y       = (row_q == '0) ? '0 : prod_y[12:0];
          res_d.tiles_in_use = cap_q - free_cnt_q;
          res_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_CLEAR: begin
        // One slot a cycle; the first tile-table rows are rebuilt alongside.
        slot_we    = 1'b1;
        slot_waddr = clr_idx_q;
        slot_wdata = '0;
        if (clr_idx_q < atc_pkg::SlotW'(atc_pkg::MaxTiles)) begin
          owner_we    = 1'b1;
          owner_waddr = clr_idx_q[atc_pkg::TileW-1:0];
          owner_wdata = '0;
          stack_we    = 1'b1;
          stack_waddr = clr_idx_q[atc_pkg::TileW-1:0];
          stack_wdata = ({1'b0, clr_idx_q} < 11'(cap_q)) ?
                        8'(cap_q - 9'd1 - clr_idx_q[atc_pkg::CntW-1:0]) : '0;
        end
        clr_idx_d = clr_idx_q + 10'd1;
        if (clr_idx_q == atc_pkg::SlotW'(atc_pkg::Slots - 1)) begin
          state_d = S_IDLE;
          if (clr_res_q) begin
            res_d              = '0;
            res_d.status       = atc_pkg::ST_DONE;
            res_d.tiles_in_use = cap_q - free_cnt_q;
            res_vld_d          = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_idx_q  <= '0;
      clr_res_q  <= 1'b0;
      res_vld_q  <= 1'b0;
      free_cnt_q <= atc_pkg::CntW'(atc_pkg::MaxTiles);
      fills_q    <= '0;
      row_q      <= 5'd16;
      cap_q      <= atc_pkg::CntW'(atc_pkg::MaxTiles);
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      scan_idx_q <= '0;
      best_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_idx_q  <= clr_idx_d;
      clr_res_q  <= clr_res_d;
      res_vld_q  <= res_vld_d;
      free_cnt_q <= free_cnt_d;
      fills_q    <= fills_d;
      row_q      <= row_d;
      cap_q      <= cap_d;
      p1_vld_q   <= p1_vld_d;
      p2_vld_q   <= p2_vld_d;
      scan_idx_q <= scan_idx_d;
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    rec_q        <= rec_d;
    tile_q       <= tile_d;
    need_q       <= need_d;
    ev_q         <= ev_d;
    best_tile_q  <= best_tile_d;
    best_slot_q  <= best_slot_d;
    best_frame_q <= best_frame_d;
    p1_tile_q    <= p1_tile_d;
    p2_tile_q    <= p2_tile_d;
    p2_slot_q    <= p2_slot_d;
    res_q        <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

  // The free stack never holds more tiles than the atlas has.
  `ATC_ASSERT(a_free_le_cap, free_cnt_q <= cap_q, "free count exceeds capacity")
  // An eviction always comes with a fill of the recycled tile.
  `ATC_ASSERT(a_evict_fill, result_valid_o && result_o.evicted |-> result_o.needs_fill,
              "eviction without fill")
  // Only a ready result carries tile fields.
  `ATC_ASSERT(a_fields_zero,
              result_valid_o && (result_o.status != atc_pkg::ST_READY) |->
              (result_o.tile_index == '0) && !result_o.needs_fill,
              "tile fields set on a result that is not ready")
  // After reset the block is busy with the clearing pass.
  `ATC_ASSERT_ALWAYS(a_reset_busy, !rst_ni |=> busy, "not busy after reset")

endmodule

>>> bench/tb_atlas_tile_cache_lru_unit.sv
// Self-checking testbench of the atlas tile cache: directed and random acquire traffic.
`timescale 1ns / 1ps
// The bench drives items through the start/busy handshake at the falling clock edge.
// It predicts each result with a behavioral model of the tile bookkeeping and
// compares it field by field with what the block shows on result_o.
// Configuration is written over APB only while the block is idle.
module tb_atlas_tile_cache_lru_unit;

  localparam int NoTile = 16'hFFFF;
  localparam longint CycleLimit = 64'd3_000_000;

  logic clk_i, rst_ni, start, busy;
  atc_pkg::item_t item_i;
  atc_pkg::result_t result_o;
  logic result_valid_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  atlas_tile_cache_lru_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_o, .result_valid_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Model state of the tile bookkeeping.
  int unsigned m_row, m_size, m_budget, m_latched, m_cap, m_free_cnt, m_fills;
  bit m_present[atc_pkg::Slots];
  logic [32:0] m_ident[atc_pkg::Slots];
  int unsigned m_tile[atc_pkg::Slots];
  int unsigned m_seen[atc_pkg::Slots];
  int unsigned m_checked[atc_pkg::Slots];
  int m_owner[atc_pkg::MaxTiles];
  int unsigned m_stack[atc_pkg::MaxTiles];

  atc_pkg::result_t pending_results[$];
  int unsigned errors;
  longint cycles;
  bit idle_free;   // no random gaps while set

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void model_rebuild();
    int unsigned sq;
    m_latched = m_row;
    sq = m_latched * m_latched;
    m_cap = sq > atc_pkg::MaxTiles ? atc_pkg::MaxTiles : sq;
    for (int i = 0; i < atc_pkg::MaxTiles; i++) begin
      m_owner[i] = -1;
      m_stack[i] = 0;
    end
    for (int i = 0; i < m_cap; i++) m_stack[i] = m_cap - 1 - i;
    m_free_cnt = m_cap;
    for (int i = 0; i < atc_pkg::Slots; i++) m_present[i] = 1'b0;
  endfunction

  function automatic int unsigned take_tile(input int unsigned frame, output bit ev);
    int unsigned best, best_frame;
    int o;
    best = NoTile;
    best_frame = frame;
    ev = 1'b0;
    if (m_free_cnt > 0) begin
      m_free_cnt--;
      return m_stack[m_free_cnt];
    end
    for (int t = 0; t < m_cap; t++) begin
      o = m_owner[t];
      if (o >= 0 && m_present[o] && m_seen[o] < best_frame) begin
        best_frame = m_seen[o];
        best = t;
      end
    end
    if (best == NoTile) return NoTile;
    m_present[m_owner[best]] = 1'b0;
    m_owner[best] = -1;
    ev = 1'b1;
    return best;
  endfunction

  function automatic atc_pkg::result_t predict_result(input atc_pkg::item_t it);
    atc_pkg::result_t r;
    int unsigned s, frame, old, t;
    logic [32:0] id;
    bit ev;
    r = '0;
    r.status = atc_pkg::ST_DONE;
    if (it.action == atc_pkg::ACT_BEGIN_FRAME) m_fills = 0;
    else if (it.action == atc_pkg::ACT_INIT) model_rebuild();
    else if (it.action == atc_pkg::ACT_ACQUIRE) begin
      s = it.texture_slot;
      id = {it.is_supported, it.identity_code};
      frame = it.frame_number;
      if (!m_present[s]) begin
        m_present[s] = 1'b1;
        m_checked[s] = frame;
        m_ident[s] = id;
        m_tile[s] = NoTile;
      end else if (m_checked[s] != frame) begin
        m_checked[s] = frame;
        if (m_ident[s] != id) begin
          old = m_tile[s];
          if (old < atc_pkg::MaxTiles) begin
            m_owner[old] = -1;
            if (m_free_cnt < m_cap) begin
              m_stack[m_free_cnt] = old;
              m_free_cnt++;
            end
          end
          m_ident[s] = id;
          m_tile[s] = NoTile;
        end
      end
      m_seen[s] = frame;
      if (!m_ident[s][32]) r.status = atc_pkg::ST_UNSUPP;
      else begin
        r.status = atc_pkg::ST_READY;
        if (m_tile[s] >= atc_pkg::MaxTiles) begin
          t = NoTile;
          ev = 1'b0;
          if (m_fills < m_budget) t = take_tile(frame, ev);
          if (t >= atc_pkg::MaxTiles) r.status = atc_pkg::ST_WAIT;
          else begin
            if (m_fills < 511) m_fills++;
            m_tile[s] = t;
            m_owner[t] = s;
            r.needs_fill = 1'b1;
            r.evicted = ev;
          end
        end
        if (r.status == atc_pkg::ST_READY) begin
          r.tile_index = m_tile[s][7:0];
          if (m_latched != 0) begin
            r.fill_x = 13'((m_tile[s] % m_latched) * m_size);
            r.fill_y = 13'((m_tile[s] / m_latched) * m_size);
          end
        end
      end
    end
    r.tiles_in_use = 9'(m_cap - m_free_cnt);
    return r;
  endfunction

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk_i) begin
    atc_pkg::result_t want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (result_o.status !== want.status)
            report_mismatch("status", result_o.status, want.status);
          if (result_o.tile_index !== want.tile_index)
            report_mismatch("tile_index", result_o.tile_index, want.tile_index);
          if (result_o.needs_fill !== want.needs_fill)
            report_mismatch("needs_fill", result_o.needs_fill, want.needs_fill);
          if (result_o.fill_x !== want.fill_x)
            report_mismatch("fill_x", result_o.fill_x, want.fill_x);
          if (result_o.fill_y !== want.fill_y)
            report_mismatch("fill_y", result_o.fill_y, want.fill_y);
          if (result_o.evicted !== want.evicted)
            report_mismatch("evicted", result_o.evicted, want.evicted);
          if (result_o.tiles_in_use !== want.tiles_in_use)
            report_mismatch("tiles_in_use", result_o.tiles_in_use, want.tiles_in_use);
        end
      end
    end
  end

  // The watchdog ends a hung run.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one item: random gap, then holds start until the block takes it.
  // Start is left high on return so that a following item can go back to back;
  // a gap or the drain task lowers it.
  task automatic send_item(input atc_pkg::item_t it);
    if (!idle_free) begin
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    item_i <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results = {pending_results, predict_result(it)};
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // APB write while idle; the model follows the register.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      atc_pkg::REG_TILES_PER_ROW: m_row = value[4:0];
      atc_pkg::REG_TILE_SIZE:     m_size = value[9:0];
      atc_pkg::REG_FILL_BUDGET:   m_budget = value[8:0];
      default: ;
    endcase
  endtask

  function automatic atc_pkg::item_t make_item(input logic [1:0] act,
                                               input int unsigned slot,
                                               input logic [31:0] id, input bit sup,
                                               input logic [31:0] frame);
    atc_pkg::item_t it;
    it.action = act;
    it.texture_slot = slot[9:0];
    it.identity_code = id;
    it.is_supported = sup;
    it.frame_number = frame;
    return it;
  endfunction

  task automatic send_init();
    send_item(make_item(atc_pkg::ACT_INIT, $urandom, $urandom, $urandom_range(1),
                        $urandom));
  endtask

  task automatic send_frame_start();
    send_item(make_item(atc_pkg::ACT_BEGIN_FRAME, $urandom, $urandom, $urandom_range(1),
                        $urandom));
  endtask

  // Directed: field extremes, every action, change of identity, budget, eviction.
  task automatic test_directed();
    write_reg(atc_pkg::REG_TILES_PER_ROW, 2);
    write_reg(atc_pkg::REG_TILE_SIZE, 512);
    write_reg(atc_pkg::REG_FILL_BUDGET, 256);
    send_init();
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 0, 32'h0, 1, 0));
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 1023, 32'hFFFF_FFFF, 1, 0));
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 5, 32'h1234, 0, 0));     // unsupported
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 6, 32'h55, 1, 1));
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 7, 32'h66, 1, 1));
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 8, 32'h77, 1, 2));       // stack empty: evict
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 9, 32'h88, 1, 2));
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 8, 32'h77, 1, 2));       // hit
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 9, 32'h99, 1, 3));       // identity changed
    send_item(make_item(2'd3, 0, 0, 0, 0));                            // unused action
    send_frame_start();
    write_reg(atc_pkg::REG_FILL_BUDGET, 0);
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 20, 32'hA, 1, 3));       // budget spent
    write_reg(atc_pkg::REG_TILES_PER_ROW, 0);
    write_reg(atc_pkg::REG_FILL_BUDGET, 16);
    send_init();
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 21, 32'hB, 1, 32'hFFFF_FFFF));  // no capacity
    write_reg(atc_pkg::REG_TILES_PER_ROW, 31);
    write_reg(atc_pkg::REG_TILE_SIZE, 8);
    send_init();
    send_item(make_item(atc_pkg::ACT_ACQUIRE, 22, 32'hC, 1, 32'hFFFF_FFFF));
    drain();
  endtask

  // Random: mostly acquires over a small slot pool with slowly rising frames.
  task automatic test_random(input int unsigned count, input int unsigned pool);
    int unsigned frame, base;
    logic [31:0] ids[16];
    int unsigned r, s;
    frame = $urandom_range(1000);
    base = $urandom_range(1023);
    for (int i = 0; i < 16; i++) ids[i] = $urandom;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (n == count / 2) drain();   // pause until all results are in
      if (r < 6) begin
        frame += $urandom_range(3);
        send_frame_start();
      end else if (r < 7) begin
        send_init();
      end else if (r < 9) begin
        send_item(make_item(2'd3, $urandom, $urandom, $urandom_range(1), $urandom));
      end else begin
        s = (base + $urandom_range(pool - 1)) % atc_pkg::Slots;
        if ($urandom_range(9) == 0) s = $urandom_range(1023);
        send_item(make_item(atc_pkg::ACT_ACQUIRE, s,
                            ($urandom_range(7) == 0) ? $urandom : ids[s % 16],
                            $urandom_range(15) != 0, frame));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0;
    cycles = 0;
    idle_free = 1'b0;
    m_row = 16; m_size = 64; m_budget = 16; m_fills = 0;
    model_rebuild();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();

    write_reg(atc_pkg::REG_TILES_PER_ROW, 3);
    write_reg(atc_pkg::REG_TILE_SIZE, 24);
    write_reg(atc_pkg::REG_FILL_BUDGET, 5);
    send_init();
    test_random(450, 24);

    idle_free = 1'b1;
    write_reg(atc_pkg::REG_TILES_PER_ROW, 16);
    write_reg(atc_pkg::REG_TILE_SIZE, 504);
    write_reg(atc_pkg::REG_FILL_BUDGET, 256);
    send_init();
    test_random(300, 300);
    idle_free = 1'b0;

    write_reg(atc_pkg::REG_TILES_PER_ROW, 1);
    write_reg(atc_pkg::REG_TILE_SIZE, 8);
    write_reg(atc_pkg::REG_FILL_BUDGET, 1);
    send_init();
    test_random(300, 6);

    write_reg(atc_pkg::REG_TILES_PER_ROW, 4);
    write_reg(atc_pkg::REG_TILE_SIZE, 136);
    write_reg(atc_pkg::REG_FILL_BUDGET, 200);
    send_init();
    test_random(380, 40);

    repeat (300) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
